@@ rtl/i2cbs_pkg.sv @@
// i2cbs_pkg: shared types, codes and helpers of the i2c master bit sequencer
// no dependencies; used by every rtl file of the block

package i2cbs_pkg;

	localparam int BYTE_BITS  = 8;
	localparam int HP_W       = 16;
	localparam int STEP_W     = 6;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam logic [HP_W-1:0] HP_RESET = HP_W'(5);
	localparam logic [STEP_W-1:0] STEP_BITS_END = STEP_W'(2 * BYTE_BITS);

	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_START = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_WRITE = 3'd3,
		REQ_READ  = 3'd4,
		REQ_ACK   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_BUS = 2'd1,
		ST_BUSY    = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_HALF_PERIOD = 1'b0
	} reg_idx_t;

	typedef enum logic [0:0] {
		PIN_SCL = 1'b0,
		PIN_SDA = 1'b1
	} pin_t;

	typedef struct packed {
		logic [STEP_W-1:0]    step;
		logic [HP_W-1:0]      hcnt;
		logic [BYTE_BITS-1:0] shift;
		logic [3:0]           bitcnt;
		logic [2:0]           cmd;
		logic                 bus;
		logic [3:0]           pins;
		logic                 ack;
	} seq_t;

	localparam seq_t SEQ_RESET = '{
		step: '0, hcnt: '0, shift: '0, bitcnt: '0,
		cmd: REQ_TICK, bus: 1'b0, pins: 4'hf, ack: 1'b1
	};

	typedef struct packed {
		logic                 scl_bus0;
		logic                 sda_bus0;
		logic                 scl_bus1;
		logic                 sda_bus1;
		logic                 busy_res;
		logic                 done_res;
		logic [BYTE_BITS-1:0] read_data;
		logic                 ack_received;
		logic [1:0]           status;
	} res_t;

	// set one pin of the selected pair
	function automatic logic [3:0] drive(logic [3:0] pins, logic bus, pin_t which,
			logic level);
		logic [3:0] p;
		p = pins;
		p[{bus, which}] = level;
		return p;
	endfunction

endpackage

@@ rtl/i2cbs_if.sv @@
// i2cbs_cmd_if and i2cbs_rsp_if: valid/ready channels of the sequencer
// depends on i2cbs_pkg for field widths

interface i2cbs_cmd_if import i2cbs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           req_type;
	logic [1:0]           bus_select;
	logic [BYTE_BITS-1:0] write_data;
	logic                 ack_to_send;
	logic                 sda_sample;

	modport source (output valid, req_type, bus_select, write_data, ack_to_send,
		sda_sample, input ready);
	modport sink (input valid, req_type, bus_select, write_data, ack_to_send,
		sda_sample, output ready);
endinterface

interface i2cbs_rsp_if import i2cbs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 scl_bus0;
	logic                 sda_bus0;
	logic                 scl_bus1;
	logic                 sda_bus1;
	logic                 busy_res;
	logic                 done_res;
	logic [BYTE_BITS-1:0] read_data;
	logic                 ack_received;
	logic [1:0]           status;

	modport source (output valid, scl_bus0, sda_bus0, scl_bus1, sda_bus1, busy_res,
		done_res, read_data, ack_received, status, input ready);
	modport sink (input valid, scl_bus0, sda_bus0, scl_bus1, sda_bus1, busy_res,
		done_res, read_data, ack_received, status, output ready);
endinterface

@@ rtl/i2cbs_core.sv @@
// i2cbs_core: next-state and result logic for one item of the sequencer
// depends on i2cbs_pkg

module i2cbs_core import i2cbs_pkg::*; (
	input  seq_t                 cur,
	input  logic [HP_W-1:0]      half_period_ticks,
	input  logic [2:0]           req_type,
	input  logic [1:0]           bus_select,
	input  logic [BYTE_BITS-1:0] write_data,
	input  logic                 ack_to_send,
	input  logic                 sda_sample,
	output seq_t                 nxt,
	output res_t                 res
);

	logic [HP_W-1:0]      hlen;
	logic                 is_cmd;
	logic                 busy;
	logic                 finish;
	logic [1:0]           status;
	logic                 done;
	logic [BYTE_BITS-1:0] rdata;

	assign hlen   = (half_period_ticks == '0) ? HP_W'(1) : half_period_ticks;
	assign is_cmd = req_type inside {[REQ_START:REQ_ACK]};
	assign busy   = cur.cmd != REQ_TICK;

	always_comb begin
		nxt    = cur;
		status = ST_OK;
		done   = 1'b0;
		rdata  = '0;
		finish = 1'b0;
		if (is_cmd && busy) begin
			status = ST_BUSY;
		end else if (is_cmd && bus_select[1]) begin
			status = ST_BAD_BUS;
		end
		if (is_cmd && !busy && !bus_select[1]) begin
			nxt.cmd    = req_type;
			nxt.bus    = bus_select[0];
			nxt.step   = '0;
			nxt.hcnt   = hlen;
			nxt.bitcnt = '0;
			case (req_type)
				REQ_START: nxt.pins = drive(cur.pins, bus_select[0], PIN_SDA, 1'b1);
				REQ_STOP:  nxt.pins = drive(cur.pins, bus_select[0], PIN_SDA, 1'b0);
				REQ_WRITE: begin
					nxt.shift = write_data;
					nxt.pins  = drive(cur.pins, bus_select[0], PIN_SDA,
						write_data[BYTE_BITS-1]);
				end
				REQ_READ: begin
					nxt.shift = '0;
					nxt.pins  = drive(cur.pins, bus_select[0], PIN_SDA, 1'b1);
				end
				default:   nxt.pins = drive(cur.pins, bus_select[0], PIN_SDA, ack_to_send);
			endcase
			nxt.pins = drive(nxt.pins, bus_select[0], PIN_SCL, 1'b1);
		end else if (busy) begin
			if (cur.hcnt > HP_W'(1)) begin
				nxt.hcnt = cur.hcnt - HP_W'(1);
			end else begin
				case (cur.cmd)
					REQ_START: begin
						if (cur.step == '0) begin
							nxt.pins = drive(cur.pins, cur.bus, PIN_SDA, 1'b0);
						end else begin
							nxt.pins = drive(cur.pins, cur.bus, PIN_SCL, 1'b0);
							finish   = 1'b1;
						end
					end
					REQ_STOP: begin
						if (cur.step == '0) begin
							nxt.pins = drive(cur.pins, cur.bus, PIN_SDA, 1'b1);
						end else begin
							finish = 1'b1;
						end
					end
					REQ_ACK: begin
						if (cur.step == '0) begin
							nxt.pins = drive(cur.pins, cur.bus, PIN_SCL, 1'b0);
						end else begin
							finish = 1'b1;
						end
					end
					REQ_WRITE: begin
						if (cur.step < STEP_BITS_END) begin
							if (!cur.step[0]) begin
								nxt.pins   = drive(cur.pins, cur.bus, PIN_SCL, 1'b0);
								nxt.shift  = {cur.shift[BYTE_BITS-2:0], 1'b0};
								nxt.bitcnt = cur.bitcnt + 4'd1;
							end else if (cur.step < STEP_BITS_END - STEP_W'(1)) begin
								nxt.pins = drive(cur.pins, cur.bus, PIN_SDA,
									cur.shift[BYTE_BITS-1]);
								nxt.pins = drive(nxt.pins, cur.bus, PIN_SCL, 1'b1);
							end else begin
								nxt.pins = drive(cur.pins, cur.bus, PIN_SDA, 1'b1);
								nxt.pins = drive(nxt.pins, cur.bus, PIN_SCL, 1'b1);
							end
						end else if (cur.step == STEP_BITS_END) begin
							nxt.ack  = sda_sample;
							nxt.pins = drive(cur.pins, cur.bus, PIN_SCL, 1'b0);
						end else begin
							finish = 1'b1;
						end
					end
					REQ_READ: begin
						if (!cur.step[0]) begin
							nxt.shift  = {cur.shift[BYTE_BITS-2:0], sda_sample};
							nxt.bitcnt = cur.bitcnt + 4'd1;
							nxt.pins   = drive(cur.pins, cur.bus, PIN_SCL, 1'b0);
						end else if (cur.step < STEP_BITS_END - STEP_W'(1)) begin
							nxt.pins = drive(cur.pins, cur.bus, PIN_SCL, 1'b1);
						end else begin
							finish = 1'b1;
							rdata  = cur.shift;
						end
					end
					default: finish = 1'b1;
				endcase
				if (finish) begin
					done     = 1'b1;
					nxt.cmd  = REQ_TICK;
					nxt.step = '0;
					nxt.hcnt = '0;
				end else begin
					nxt.step = cur.step + STEP_W'(1);
					nxt.hcnt = hlen;
				end
			end
		end
	end

	always_comb begin
		res.scl_bus0     = nxt.pins[0];
		res.sda_bus0     = nxt.pins[1];
		res.scl_bus1     = nxt.pins[2];
		res.sda_bus1     = nxt.pins[3];
		res.busy_res     = nxt.cmd != REQ_TICK;
		res.done_res     = done;
		res.read_data    = rdata;
		res.ack_received = nxt.ack;
		res.status       = status;
	end

endmodule

@@ rtl/i2c_master_bit_sequencer.sv @@
// i2c_master_bit_sequencer: top level, apb register, sequencer state, result register
// depends on i2cbs_pkg, i2cbs_if and i2cbs_core
//
// usage: each item on cmd is one tick of the bit timing, optionally carrying
// a command (start, stop, write byte, read byte, send ack) for pin pair 0 or 1.
// every accepted item yields exactly one item on rsp with the pin levels of
// both pairs, busy, done, the read byte, the last acknowledge and a status.
// half_period_ticks (apb address 0) sets items per scl half period; write it
// only while idle. a command while busy or for pair 2 or 3 is flagged in status.
// the result is registered and appears in the cycle after the item is accepted.
// throughput: one item per cycle while rsp is taken; the state update is a single pass of
// combinational logic feeding the state and result registers.
// the result register frees itself as it is taken, so cmd.ready stays high
// while rsp is taken every cycle; if rsp stalls, cmd.ready drops until the
// waiting result is taken.
// reset: all pins released high, no command active, acknowledge latch one,
// half period five, no result pending.

module i2c_master_bit_sequencer import i2cbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	i2cbs_cmd_if.sink          cmd,
	i2cbs_rsp_if.source        rsp
);

	logic [HP_W-1:0] hp_q;
	seq_t            seq_q;
	seq_t            seq_nxt;
	res_t            res_nxt;
	res_t            res_q;
	logic            rsp_valid_q;
	logic            take;
	logic            sel_hp;

	assign pready = 1'b1;
	assign sel_hp = paddr[PADDR_W-1] == REG_HALF_PERIOD;
	assign prdata = sel_hp ? PDATA_W'(hp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HP_RESET;
		end else if (psel && penable && pwrite && pready && sel_hp) begin
			hp_q <= pwdata[HP_W-1:0];
		end
	end

	i2cbs_core u_core (
		.cur               (seq_q),
		.half_period_ticks (hp_q),
		.req_type          (cmd.req_type),
		.bus_select        (cmd.bus_select),
		.write_data        (cmd.write_data),
		.ack_to_send       (cmd.ack_to_send),
		.sda_sample        (cmd.sda_sample),
		.nxt               (seq_nxt),
		.res               (res_nxt)
	);

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign take      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				seq_q <= seq_nxt;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.scl_bus0     = res_q.scl_bus0;
	assign rsp.sda_bus0     = res_q.sda_bus0;
	assign rsp.scl_bus1     = res_q.scl_bus1;
	assign rsp.sda_bus1     = res_q.sda_bus1;
	assign rsp.busy_res     = res_q.busy_res;
	assign rsp.done_res     = res_q.done_res;
	assign rsp.read_data    = res_q.read_data;
	assign rsp.ack_received = res_q.ack_received;
	assign rsp.status       = res_q.status;

endmodule

@@ rtl/i2cbs_checker.sv @@
// i2cbs_checker: port-level assertions for the sequencer, bound to the top level
// depends on i2cbs_pkg and i2c_master_bit_sequencer

module i2cbs_checker import i2cbs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 busy_res,
	input logic                 done_res,
	input logic [BYTE_BITS-1:0] read_data,
	input logic [1:0]           status
);

	// every accepted item produces a result next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> rsp_valid)
		else $error("accepted item gave no result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !busy_res)
		else $error("done and busy together");

	a_bad_bus_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_BAD_BUS |-> !busy_res && !done_res)
		else $error("bad bus command started a sequence");

	a_rdata_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_data != '0 |-> done_res)
		else $error("read data without done");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.busy_res  (rsp.busy_res),
	.done_res  (rsp.done_res),
	.read_data (rsp.read_data),
	.status    (rsp.status)
);

@@ dv/i2c_master_bit_sequencer_tb.sv @@
// i2c_master_bit_sequencer_tb: self-checking bench for the i2c bit sequencer; a tick-level
// model predicts pins, busy, done, read byte, ack and status for every item
// depends on i2cbs_pkg, i2cbs_cmd_if, i2cbs_rsp_if and the rtl of i2c_master_bit_sequencer

module i2c_master_bit_sequencer_tb;
	import i2cbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REQ_SPARE6 = 3'd6;
	localparam logic [2:0] REQ_SPARE7 = 3'd7;

	typedef struct packed {
		logic [2:0] req;
		logic [1:0] bus_sel;
		logic [7:0] wdata;
		logic       ack_bit;
		logic       sda;
	} cmd_item_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	i2cbs_cmd_if cmd_ch ();
	i2cbs_rsp_if rsp_ch ();

	i2c_master_bit_sequencer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer model state
	logic [HP_W-1:0]      cfg_half_period = HP_RESET;
	logic [STEP_W-1:0]    sq_step = '0;
	logic [HP_W-1:0]      sq_count = '0;
	logic [BYTE_BITS-1:0] sq_shift = '0;
	req_t                 sq_cmd = REQ_TICK;
	logic                 sq_bus = 1'b0;
	logic [3:0]           line_levels = 4'hf;
	logic                 ack_seen = 1'b1;

	cmd_item_t   tick_queue[$];
	res_t        awaited_reports[$];
	int unsigned items_queued = 0;
	int unsigned items_sent = 0;
	int unsigned items_accepted = 0;
	int unsigned reports_checked = 0;
	int unsigned mismatches = 0;
	int unsigned sequences_done = 0;
	int unsigned bytes_read = 0;
	int unsigned refused_busy = 0;
	int unsigned refused_bus = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        cmd_fire = 1'b0;
	logic        hold_for_drain = 1'b0;

	function automatic logic [HP_W-1:0] period_span();
		return (cfg_half_period == '0) ? HP_W'(1) : cfg_half_period;
	endfunction

	function automatic void set_line(pin_t which, logic level);
		line_levels[{sq_bus, which}] = level;
	endfunction

	// acts where a phase ends, returns 1 when the command is finished
	function automatic logic end_of_phase(logic sda);
		case (sq_cmd)
			REQ_START: begin
				if (sq_step == '0) begin
					set_line(PIN_SDA, 1'b0);
					return 1'b0;
				end
				set_line(PIN_SCL, 1'b0);
				return 1'b1;
			end
			REQ_STOP: begin
				if (sq_step == '0) begin
					set_line(PIN_SDA, 1'b1);
					return 1'b0;
				end
				return 1'b1;
			end
			REQ_ACK: begin
				if (sq_step == '0) begin
					set_line(PIN_SCL, 1'b0);
					return 1'b0;
				end
				return 1'b1;
			end
			REQ_WRITE: begin
				if (sq_step < STEP_BITS_END) begin
					if (!sq_step[0]) begin
						set_line(PIN_SCL, 1'b0);
						sq_shift = sq_shift << 1;
					end else if (sq_step < STEP_BITS_END - 1) begin
						set_line(PIN_SDA, sq_shift[7]);
						set_line(PIN_SCL, 1'b1);
					end else begin
						set_line(PIN_SDA, 1'b1);
						set_line(PIN_SCL, 1'b1);
					end
					return 1'b0;
				end
				if (sq_step == STEP_BITS_END) begin
					ack_seen = sda;
					set_line(PIN_SCL, 1'b0);
					return 1'b0;
				end
				return 1'b1;
			end
			REQ_READ: begin
				if (!sq_step[0]) begin
					sq_shift = {sq_shift[BYTE_BITS-2:0], sda};
					set_line(PIN_SCL, 1'b0);
					return 1'b0;
				end
				if (sq_step < STEP_BITS_END - 1) begin
					set_line(PIN_SCL, 1'b1);
					return 1'b0;
				end
				return 1'b1;
			end
			default: return 1'b1;
		endcase
	endfunction

	function automatic res_t advance_bus(cmd_item_t it);
		res_t r;
		logic launched;
		r = '0;
		r.status = ST_OK;
		launched = 1'b0;
		if (it.req >= REQ_START && it.req <= REQ_ACK) begin
			if (sq_cmd != REQ_TICK)
				r.status = ST_BUSY;
			else if (it.bus_sel[1])
				r.status = ST_BAD_BUS;
			else begin
				launched = 1'b1;
				sq_cmd = req_t'(it.req);
				sq_bus = it.bus_sel[0];
				sq_step = '0;
				sq_count = period_span();
				set_line(PIN_SCL, 1'b1);
				case (sq_cmd)
					REQ_START: set_line(PIN_SDA, 1'b1);
					REQ_STOP: set_line(PIN_SDA, 1'b0);
					REQ_WRITE: begin
						sq_shift = it.wdata;
						set_line(PIN_SDA, it.wdata[7]);
					end
					REQ_READ: begin
						sq_shift = '0;
						set_line(PIN_SDA, 1'b1);
					end
					default: set_line(PIN_SDA, it.ack_bit);
				endcase
			end
		end
		if (!launched && sq_cmd != REQ_TICK) begin
			if (sq_count > 1)
				sq_count--;
			else if (end_of_phase(it.sda)) begin
				r.done_res = 1'b1;
				if (sq_cmd == REQ_READ)
					r.read_data = sq_shift;
				sq_cmd = REQ_TICK;
				sq_step = '0;
				sq_count = '0;
			end else begin
				sq_step++;
				sq_count = period_span();
			end
		end
		r.scl_bus0 = line_levels[0];
		r.sda_bus0 = line_levels[1];
		r.scl_bus1 = line_levels[2];
		r.sda_bus1 = line_levels[3];
		r.busy_res = (sq_cmd != REQ_TICK);
		r.ack_received = ack_seen;
		return r;
	endfunction

	function automatic string show_res(res_t r);
		return $sformatf("scl0=%b sda0=%b scl1=%b sda1=%b busy=%b done=%b rd=%h ack=%b st=%0d",
			r.scl_bus0, r.sda_bus0, r.scl_bus1, r.sda_bus1, r.busy_res, r.done_res,
			r.read_data, r.ack_received, r.status);
	endfunction

	// stimulus building
	function automatic void queue_item(logic [2:0] rq, logic [1:0] bs, logic [7:0] wd,
			logic ab);
		cmd_item_t it;
		it.req = rq;
		it.bus_sel = bs;
		it.wdata = wd;
		it.ack_bit = ab;
		it.sda = 1'($urandom_range(1));
		tick_queue.push_back(it);
		items_queued++;
	endfunction

	function automatic void queue_ticks(int n);
		logic [2:0] rq;
		for (int k = 0; k < n; k++) begin
			rq = REQ_TICK;
			if ($urandom_range(19) == 0)
				rq = $urandom_range(1) ? REQ_SPARE7 : REQ_SPARE6;
			queue_item(rq, 2'($urandom), 8'($urandom), 1'($urandom));
		end
	endfunction

	function automatic int cmd_ticks(req_t rq, int span);
		case (rq)
			REQ_WRITE: return 18 * span;
			REQ_READ: return 16 * span;
			default: return 2 * span;
		endcase
	endfunction

	function automatic void queue_cmd(req_t rq, logic bus, int span, logic [7:0] wd,
			logic ab);
		int n;
		int roll;
		logic [1:0] bs;
		roll = $urandom_range(99);
		bs = {1'b0, bus};
		n = cmd_ticks(rq, span);
		if (roll < 5)
			bs = 2'($urandom_range(3, 2));
		// one tick short makes the following command land while still busy
		if (roll >= 5 && roll < 13)
			n = n - 1;
		else
			n = n + $urandom_range(2);
		if (roll >= 95)
			queue_item(3'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
		queue_item(rq, bs, wd, ab);
		queue_ticks(n);
	endfunction

	function automatic void queue_transaction(int span);
		logic bus;
		int nops;
		bus = 1'($urandom_range(1));
		nops = $urandom_range(3, 1);
		queue_cmd(REQ_START, bus, span, 8'($urandom), 1'($urandom));
		for (int k = 0; k < nops; k++) begin
			if ($urandom_range(1))
				queue_cmd(REQ_WRITE, bus, span, 8'($urandom), 1'($urandom));
			else begin
				queue_cmd(REQ_READ, bus, span, 8'($urandom), 1'($urandom));
				queue_cmd(REQ_ACK, bus, span, 8'($urandom), 1'($urandom));
			end
		end
		queue_cmd(REQ_STOP, bus, span, 8'($urandom), 1'($urandom));
	endfunction

	// driver
	always @(negedge clk) begin
		cmd_item_t nxt;
		if (hold_for_drain && items_accepted == items_sent && awaited_reports.size() == 0)
			hold_for_drain = 1'b0;
		if (!cmd_ch.valid || cmd_fire) begin
			if (tick_queue.size() != 0 && !hold_for_drain &&
					$urandom_range(99) >= send_idle_pct) begin
				nxt = tick_queue.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.req_type <= nxt.req;
				cmd_ch.bus_select <= nxt.bus_sel;
				cmd_ch.write_data <= nxt.wdata;
				cmd_ch.ack_to_send <= nxt.ack_bit;
				cmd_ch.sda_sample <= nxt.sda;
				items_sent++;
				if (items_sent % 400 == 200)
					hold_for_drain = 1'b1;
			end else
				cmd_ch.valid <= 1'b0;
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor and checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		cmd_item_t it;
		if (!arst_n)
			cmd_fire <= 1'b0;
		else begin
			cmd_fire <= cmd_ch.valid && cmd_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.scl_bus0 = rsp_ch.scl_bus0;
				got.sda_bus0 = rsp_ch.sda_bus0;
				got.scl_bus1 = rsp_ch.scl_bus1;
				got.sda_bus1 = rsp_ch.sda_bus1;
				got.busy_res = rsp_ch.busy_res;
				got.done_res = rsp_ch.done_res;
				got.read_data = rsp_ch.read_data;
				got.ack_received = rsp_ch.ack_received;
				got.status = rsp_ch.status;
				if (awaited_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item on rsp: %s", show_res(got));
				end else begin
					want = awaited_reports.pop_front();
					reports_checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch on item %0d\n  expected %s\n  actual   %s",
								reports_checked, show_res(want), show_res(got));
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				it.req = cmd_ch.req_type;
				it.bus_sel = cmd_ch.bus_select;
				it.wdata = cmd_ch.write_data;
				it.ack_bit = cmd_ch.ack_to_send;
				it.sda = cmd_ch.sda_sample;
				want = advance_bus(it);
				awaited_reports.push_back(want);
				items_accepted <= items_accepted + 1;
				if (want.done_res)
					sequences_done++;
				if (want.done_res && it.req == REQ_TICK && want.read_data != '0)
					bytes_read++;
				if (want.status == ST_BUSY)
					refused_busy++;
				if (want.status == ST_BAD_BUS)
					refused_bus++;
			end
		end
	end

	// register access
	task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] wdat,
			output logic [PDATA_W-1:0] rdat);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'(4 * int'(REG_HALF_PERIOD));
		pwdata <= wdat;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdat = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_half_period(logic [HP_W-1:0] val);
		logic [PDATA_W-1:0] rd;
		apb_transfer(1'b0, '0, rd);
		if (rd[HP_W-1:0] !== val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("half period readback: expected %0d, actual %0d", val, rd[HP_W-1:0]);
		end
	endtask

	task automatic write_half_period(logic [HP_W-1:0] val);
		logic [PDATA_W-1:0] rd;
		apb_transfer(1'b1, {16'($urandom), val}, rd);
		cfg_half_period = val;
		check_half_period(val);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (items_accepted != items_queued || awaited_reports.size() != 0);
	endtask

	// ticks until the model is back to idle so the register may be written
	task automatic settle_sequencer();
		wait_drained();
		while (sq_cmd != REQ_TICK) begin
			queue_ticks(period_span());
			wait_drained();
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic run_random_phase(int unsigned send_pct, int unsigned recv_pct,
			logic [HP_W-1:0] hp, int target);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_half_period(hp);
		while (tick_queue.size() < target)
			queue_transaction(period_span());
		settle_sequencer();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.req_type = REQ_TICK;
		cmd_ch.bus_select = '0;
		cmd_ch.write_data = '0;
		cmd_ch.ack_to_send = 1'b0;
		cmd_ch.sda_sample = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_half_period(HP_RESET);
		send_idle_pct = 30;
		recv_idle_pct = 52;

		// directed: spare code, bad bus, busy refusal, zero half period, all-ones byte
		queue_item(REQ_SPARE7, 2'd1, 8'hff, 1'b1);
		queue_item(REQ_STOP, 2'd2, 8'h00, 1'b0);
		queue_item(REQ_ACK, 2'd3, 8'h5a, 1'b1);
		queue_item(REQ_START, 2'd1, 8'h00, 1'b0);
		queue_item(REQ_READ, 2'd0, 8'h00, 1'b0);
		queue_ticks(9);
		settle_sequencer();
		write_half_period('0);
		queue_item(REQ_WRITE, 2'd0, 8'hff, 1'b0);
		queue_ticks(18);
		settle_sequencer();

		run_random_phase(30, 52, HP_W'(1), 600);
		run_random_phase(52, 30, HP_W'(3), 600);
		run_random_phase(0, 0, HP_W'(2), 520);

		// longest half period: readback, a bad-bus start and idle items
		write_half_period(16'hffff);
		queue_item(REQ_START, 2'd2, 8'h00, 1'b0);
		queue_item(REQ_SPARE6, 2'd0, 8'ha5, 1'b0);
		queue_ticks(4);
		settle_sequencer();

		wait_drained();
		repeat (5) @(negedge clk);
		$display("checked %0d results of %0d items over half periods 5, 0, 1, 3, 2 and 65535",
			reports_checked, items_accepted);
		$display("%0d sequences finished, %0d nonzero bytes read, %0d refused busy, %0d bad bus",
			sequences_done, bytes_read, refused_busy, refused_bus);
		if (mismatches == 0)
			$display("** i2c_master_bit_sequencer: PASSED **");
		else
			$display("** i2c_master_bit_sequencer: FAILED **");
		$finish;
	end

	initial begin
		#(64'd15_000_000);
		$display("timeout after %0d of %0d items", items_accepted, items_queued);
		$display("** i2c_master_bit_sequencer: FAILED **");
		$finish;
	end

endmodule
